// ===== sv/sckq_pkg.sv =====
`timescale 1ns / 1ps

package sckq_pkg;

   // fixed payload widths
   localparam int BYTE_W = 8;
   localparam int FILL_W = 9;
   localparam int PAUSE_W = 3;

   // special scan bytes and keys
   localparam logic [BYTE_W-1:0] EXT_PREFIX = 8'he0;
   localparam logic [BYTE_W-1:0] PAUSE_PREFIX = 8'he1;
   localparam logic [BYTE_W-1:0] PAUSE_KEY = 8'h10;
   localparam logic [PAUSE_W-1:0] PAUSE_LAST = 3'd6;

   // item opcodes
   localparam logic OP_SCAN = 1'b0;
   localparam logic OP_POP = 1'b1;

   // decode result handed from the decoder to the queue control
   typedef struct packed {
      logic produced;
      logic [BYTE_W-1:0] key;
   } decode_type;

   // normal table, entries past 88 read as zero
   function automatic logic [BYTE_W-1:0] normal_rom(input logic [6:0] idx);
      logic [BYTE_W-1:0] val;
      unique case (idx)
         7'd0: val = 8'h00;  7'd1: val = 8'h01;  7'd2: val = 8'h12;  7'd3: val = 8'h13;
         7'd4: val = 8'h14;  7'd5: val = 8'h15;  7'd6: val = 8'h16;  7'd7: val = 8'h17;
         7'd8: val = 8'h18;  7'd9: val = 8'h19;  7'd10: val = 8'h1a; 7'd11: val = 8'h1b;
         7'd12: val = 8'h1c; 7'd13: val = 8'h1d; 7'd14: val = 8'h1e; 7'd15: val = 8'h26;
         7'd16: val = 8'h27; 7'd17: val = 8'h28; 7'd18: val = 8'h29; 7'd19: val = 8'h2a;
         7'd20: val = 8'h2b; 7'd21: val = 8'h2c; 7'd22: val = 8'h2d; 7'd23: val = 8'h2e;
         7'd24: val = 8'h2f; 7'd25: val = 8'h30; 7'd26: val = 8'h31; 7'd27: val = 8'h32;
         7'd28: val = 8'h47; 7'd29: val = 8'h5c; 7'd30: val = 8'h3c; 7'd31: val = 8'h3d;
         7'd32: val = 8'h3e; 7'd33: val = 8'h3f; 7'd34: val = 8'h40; 7'd35: val = 8'h41;
         7'd36: val = 8'h42; 7'd37: val = 8'h43; 7'd38: val = 8'h44; 7'd39: val = 8'h45;
         7'd40: val = 8'h46; 7'd41: val = 8'h11; 7'd42: val = 8'h4b; 7'd43: val = 8'h33;
         7'd44: val = 8'h4c; 7'd45: val = 8'h4d; 7'd46: val = 8'h4e; 7'd47: val = 8'h4f;
         7'd48: val = 8'h50; 7'd49: val = 8'h51; 7'd50: val = 8'h52; 7'd51: val = 8'h53;
         7'd52: val = 8'h54; 7'd53: val = 8'h55; 7'd54: val = 8'h56; 7'd55: val = 8'h24;
         7'd56: val = 8'h5d; 7'd57: val = 8'h5e; 7'd58: val = 8'h3b; 7'd59: val = 8'h02;
         7'd60: val = 8'h03; 7'd61: val = 8'h04; 7'd62: val = 8'h05; 7'd63: val = 8'h06;
         7'd64: val = 8'h07; 7'd65: val = 8'h08; 7'd66: val = 8'h09; 7'd67: val = 8'h0a;
         7'd68: val = 8'h0b; 7'd69: val = 8'h22; 7'd70: val = 8'h0f; 7'd71: val = 8'h37;
         7'd72: val = 8'h38; 7'd73: val = 8'h39; 7'd74: val = 8'h25; 7'd75: val = 8'h48;
         7'd76: val = 8'h49; 7'd77: val = 8'h4a; 7'd78: val = 8'h3a; 7'd79: val = 8'h58;
         7'd80: val = 8'h59; 7'd81: val = 8'h5a; 7'd82: val = 8'h64; 7'd83: val = 8'h65;
         7'd84: val = 8'h7e; 7'd85: val = 8'h00; 7'd86: val = 8'h69; 7'd87: val = 8'h0c;
         7'd88: val = 8'h0d;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

   // table for keys after the extended prefix
   function automatic logic [BYTE_W-1:0] extended_rom(input logic [6:0] idx);
      logic [BYTE_W-1:0] val;
      unique case (idx)
         7'd28: val = 8'h5b;
         7'd29: val = 8'h60;
         7'd53: val = 8'h23;
         7'd55: val = 8'h0e;
         7'd56: val = 8'h5f;
         7'd70: val = 8'h7f;
         7'd71: val = 8'h20;
         7'd72: val = 8'h57;
         7'd73: val = 8'h21;
         7'd75: val = 8'h61;
         7'd77: val = 8'h63;
         7'd79: val = 8'h35;
         7'd80: val = 8'h62;
         7'd81: val = 8'h36;
         7'd82: val = 8'h1f;
         7'd83: val = 8'h34;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

endpackage

// ===== sv/sckq_req_if.sv =====
`timescale 1ns / 1ps

interface sckq_req_if;
   logic valid;
   logic ready;
   logic op;
   logic [sckq_pkg::BYTE_W-1:0] scan_byte;

   modport source (output valid, output op, output scan_byte, input ready);
   modport sink (input valid, input op, input scan_byte, output ready);
endinterface

// ===== sv/sckq_rsp_if.sv =====
`timescale 1ns / 1ps

interface sckq_rsp_if;
   logic valid;
   logic ready;
   logic key_valid;
   logic [sckq_pkg::BYTE_W-1:0] key_code;
   logic overflow;
   logic read_valid;
   logic [sckq_pkg::BYTE_W-1:0] read_data;
   logic [sckq_pkg::FILL_W-1:0] fill_level;

   modport source (output valid, output key_valid, output key_code, output overflow,
                   output read_valid, output read_data, output fill_level, input ready);
   modport sink (input valid, input key_valid, input key_code, input overflow,
                 input read_valid, input read_data, input fill_level, output ready);
endinterface

// ===== sv/sckq_ram.sv =====
`timescale 1ns / 1ps

module sckq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/sckq_decoder.sv =====
`timescale 1ns / 1ps

module sckq_decoder (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        scan_en,
   input  logic [sckq_pkg::BYTE_W-1:0] scan_byte,
   output sckq_pkg::decode_type        decode
);

   logic [sckq_pkg::BYTE_W-1:0]  prev_byte_ff, prev_byte_in;
   logic [sckq_pkg::BYTE_W-1:0]  last_key_ff, last_key_in;
   logic [sckq_pkg::PAUSE_W-1:0] pause_ff, pause_in;
   logic [sckq_pkg::PAUSE_W-1:0] pause_inc;
   logic [sckq_pkg::BYTE_W-1:0]  base;
   logic [sckq_pkg::BYTE_W-1:0]  full_key;

   // table lookup on the low seven bits, release flag passed through
   always_comb begin
      if (prev_byte_ff == sckq_pkg::EXT_PREFIX) begin
         base = sckq_pkg::extended_rom(scan_byte[6:0]);
      end else if (scan_byte != sckq_pkg::EXT_PREFIX) begin
         base = sckq_pkg::normal_rom(scan_byte[6:0]);
      end else begin
         base = '0;
      end
      full_key = base | {scan_byte[7], 7'b0};
      pause_inc = pause_ff + 1'b1;
   end

   // pause sequence, prefix tracking and repeat suppression
   always_comb begin
      prev_byte_in = prev_byte_ff;
      last_key_in = last_key_ff;
      pause_in = pause_ff;
      decode.produced = 1'b0;
      decode.key = full_key;
      priority if (pause_ff != '0) begin
         if (pause_inc == sckq_pkg::PAUSE_LAST) begin
            pause_in = '0;
            decode.produced = 1'b1;
            decode.key = sckq_pkg::PAUSE_KEY;
         end else begin
            pause_in = pause_inc;
         end
      end else if (scan_byte == sckq_pkg::PAUSE_PREFIX) begin
         pause_in = {{(sckq_pkg::PAUSE_W-1){1'b0}}, 1'b1};
      end else begin
         prev_byte_in = scan_byte;
         if (base != '0 && full_key != last_key_ff) begin
            last_key_in = full_key;
            decode.produced = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_byte_ff <= '0;
         last_key_ff <= '0;
         pause_ff <= '0;
      end else if (scan_en) begin
         prev_byte_ff <= prev_byte_in;
         last_key_ff <= last_key_in;
         pause_ff <= pause_in;
      end
   end

endmodule

// ===== sv/scancode_to_keycode_fifo_top.sv =====
`timescale 1ns / 1ps

// Set 1 scan code decoder with a key queue. Each request beat is either a
// scan byte (op 0) or a pop (op 1) and gives exactly one response beat. The
// block takes one request beat per cycle unless the output stalls. Responses
// pass the middle stage, which waits for the RAM's registered read, then the
// output register. Queue state lives in a single-port-write, single-port-read
// RAM of QUEUE_DEPTH entries; a push and a pop never share a cycle, so no
// forwarding is needed. A key produced on a full queue is dropped and flagged
// with overflow. No clearing pass: the fill count guards every read.

module scancode_to_keycode_fifo_top #(
   parameter int QUEUE_DEPTH = 256
) (
   input logic        clock,
   input logic        reset,
   sckq_req_if.sink   req_chan,
   sckq_rsp_if.source rsp_chan
);

   localparam int AddrW = $clog2(QUEUE_DEPTH);
   localparam int CountW = $clog2(QUEUE_DEPTH + 1);
   localparam int FillW = sckq_pkg::FILL_W;
   localparam logic [AddrW-1:0] LastAddr = AddrW'(QUEUE_DEPTH - 1);
   localparam logic [CountW-1:0] FullCount = CountW'(QUEUE_DEPTH);

   sckq_pkg::decode_type decode;

   logic accept, is_scan, is_pop;
   logic full, push, pop, drop;
   logic out_free, s1_move;

   logic [AddrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [AddrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CountW-1:0] count_ff, count_in;
   logic [sckq_pkg::BYTE_W-1:0] ram_rd_data;

   // middle stage: waits for the RAM read data
   logic s1_valid_ff, s1_valid_in;
   logic s1_key_valid_ff, s1_overflow_ff, s1_pop_ff;
   logic [sckq_pkg::BYTE_W-1:0] s1_key_code_ff;
   logic [CountW-1:0] s1_count_ff;

   // output register
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_key_valid_ff, rsp_overflow_ff, rsp_read_valid_ff;
   logic [sckq_pkg::BYTE_W-1:0] rsp_key_code_ff, rsp_read_data_ff;
   logic [CountW-1:0] rsp_count_ff;

   // handshake
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign s1_move = s1_valid_ff && out_free;
   assign req_chan.ready = !s1_valid_ff || out_free;
   assign accept = req_chan.valid && req_chan.ready;
   assign is_scan = accept && (req_chan.op == sckq_pkg::OP_SCAN);
   assign is_pop = accept && (req_chan.op == sckq_pkg::OP_POP);

   sckq_decoder u_decoder (
      .clock     (clock),
      .reset     (reset),
      .scan_en   (is_scan),
      .scan_byte (req_chan.scan_byte),
      .decode    (decode)
   );

   // queue control
   assign full = (count_ff == FullCount);
   assign push = is_scan && decode.produced && !full;
   assign drop = is_scan && decode.produced && full;
   assign pop = is_pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastAddr) ? '0 : wr_ptr_ff + 1'b1;
         count_in = count_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastAddr) ? '0 : rd_ptr_ff + 1'b1;
         count_in = count_ff - 1'b1;
      end
   end

   sckq_ram #(
      .WIDTH (sckq_pkg::BYTE_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (wr_ptr_ff),
      .wr_data (decode.key),
      .rd_en   (pop),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // middle stage valid
   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // middle stage payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_key_valid_ff <= push;
         s1_overflow_ff <= drop;
         s1_key_code_ff <= (is_scan && decode.produced) ? decode.key : '0;
         s1_pop_ff <= pop;
         s1_count_ff <= count_in;
      end
   end

   // output register valid
   always_comb begin
      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output register payload, read data joins here
   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_key_valid_ff <= s1_key_valid_ff;
         rsp_key_code_ff <= s1_key_code_ff;
         rsp_overflow_ff <= s1_overflow_ff;
         rsp_read_valid_ff <= s1_pop_ff;
         rsp_read_data_ff <= s1_pop_ff ? ram_rd_data : '0;
         rsp_count_ff <= s1_count_ff;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.key_valid = rsp_key_valid_ff;
   assign rsp_chan.key_code = rsp_key_code_ff;
   assign rsp_chan.overflow = rsp_overflow_ff;
   assign rsp_chan.read_valid = rsp_read_valid_ff;
   assign rsp_chan.read_data = rsp_read_data_ff;
   assign rsp_chan.fill_level = FillW'(rsp_count_ff);

endmodule
